### rtl/gost_pkg.sv
// Shared types, constants and round functions for the GOST block cipher unit.
`timescale 1ns / 1ps

package gost_pkg;

  // Fixed cipher geometry.
  localparam int unsigned ROUND_COUNT = 32;
  localparam int unsigned ROUND_W     = $clog2(ROUND_COUNT);
  localparam int unsigned HALF_W      = 32;
  localparam int unsigned KEY_WORDS   = 8;
  localparam int unsigned KEY_SEL_W   = $clog2(KEY_WORDS);
  localparam int unsigned CFG_W       = 64;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned ROT_AMOUNT  = 11;
  localparam int unsigned SBOX_COUNT  = 8;
  localparam int unsigned NIB_W       = 4;

  // Rounds that use the forward key order before the reversed tail.
  localparam int unsigned ENC_FWD_ROUNDS = 24;
  localparam int unsigned DEC_FWD_ROUNDS = 8;

  // Default substitution table set.
  localparam int unsigned SBOX_SET_DEFAULT = 0;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIRECTION = 3'd0,
    CFG_KEY_01    = 3'd1,
    CFG_KEY_23    = 3'd2,
    CFG_KEY_45    = 3'd3,
    CFG_KEY_67    = 3'd4
  } cfg_idx_t;

  // Key order selected by the direction register.
  typedef enum logic {
    DIR_ENCRYPT = 1'b0,
    DIR_DECRYPT = 1'b1
  } dir_t;

  // Input request payload.
  typedef struct packed {
    logic [HALF_W-1:0] in_first;
    logic [HALF_W-1:0] in_second;
  } in_req_t;

  // Output request payload.
  typedef struct packed {
    logic [HALF_W-1:0] out_first;
    logic [HALF_W-1:0] out_second;
  } out_req_t;

  // Block state handed from one round cell to the next.
  typedef struct packed {
    logic [HALF_W-1:0] first;
    logic [HALF_W-1:0] second;
  } blk_t;

  // Configuration seen by every round cell.
  typedef struct packed {
    dir_t                            direction;
    logic [KEY_WORDS-1:0][HALF_W-1:0] key;
  } cfg_t;

  // Substitution tables: entry n of a box sits in bits 4n+3..4n of its row.
  localparam logic [63:0] SBOX_ROM [2][SBOX_COUNT] = '{
    '{64'h35F7C1B6E08D29A4, 64'h95701832AFD6C4BE,
      64'hB9067CFE243AD185, 64'h352BC64EF9801AD7,
      64'h2B30E9A48DF517C6, 64'hEFC95863D1270AB4,
      64'hC2867EA095F314BD, 64'hC8B6E3294A750DF1},
    '{64'h1F307D8E9B5A264C, 64'hF0DB74E1C5A93286,
      64'h069C471EDAF2853B, 64'hB9E35A076F4D128C,
      64'hC24BE390D618A5F7, 64'h0E34187BAC296FD5,
      64'h73AD0B4FC19652E8, 64'h2BC96AF43850DE71}
  };

  // Key word used by a given round for a given direction.
  function automatic logic [KEY_SEL_W-1:0] key_sel(input logic [ROUND_W-1:0] rnd,
                                                   input dir_t dir);
    logic fwd;
    begin
      if (dir == DIR_ENCRYPT) begin
        fwd = (rnd < ROUND_W'(ENC_FWD_ROUNDS));
      end else begin
        fwd = (rnd < ROUND_W'(DEC_FWD_ROUNDS));
      end
      key_sel = fwd ? rnd[KEY_SEL_W-1:0] : ~rnd[KEY_SEL_W-1:0];
    end
  endfunction

  // Eight parallel nibble substitutions followed by a rotate left by 11.
  function automatic logic [HALF_W-1:0] round_f(input logic set,
                                                input logic [HALF_W-1:0] x);
    logic [HALF_W-1:0] y;
    logic [63:0]       row;
    begin
      y = '0;
      for (int j = 0; j < SBOX_COUNT; j++) begin
        row = SBOX_ROM[set][j];
        y[NIB_W*j +: NIB_W] = row[NIB_W*x[NIB_W*j +: NIB_W] +: NIB_W];
      end
      round_f = {y[HALF_W-ROT_AMOUNT-1:0], y[HALF_W-1:HALF_W-ROT_AMOUNT]};
    end
  endfunction

endpackage

### rtl/gost_cfg.sv
// Configuration register file holding the direction and the eight key words.
`timescale 1ns / 1ps

module gost_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [gost_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [gost_pkg::CFG_W-1:0]          cfg_data,
  output gost_pkg::cfg_t                      cfg
);
  import gost_pkg::*;

  dir_t                              direction;
  logic [KEY_WORDS-1:0][HALF_W-1:0]  key;

  // Register writes; indexes past the last register are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      direction <= DIR_ENCRYPT;
      key       <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_DIRECTION: direction <= dir_t'(cfg_data[0]);
        CFG_KEY_01: begin
          key[0] <= cfg_data[CFG_W-1:HALF_W];
          key[1] <= cfg_data[HALF_W-1:0];
        end
        CFG_KEY_23: begin
          key[2] <= cfg_data[CFG_W-1:HALF_W];
          key[3] <= cfg_data[HALF_W-1:0];
        end
        CFG_KEY_45: begin
          key[4] <= cfg_data[CFG_W-1:HALF_W];
          key[5] <= cfg_data[HALF_W-1:0];
        end
        CFG_KEY_67: begin
          key[6] <= cfg_data[CFG_W-1:HALF_W];
          key[7] <= cfg_data[HALF_W-1:0];
        end
        default: ;
      endcase
    end
  end

  assign cfg.direction = direction;
  assign cfg.key       = key;

endmodule

### rtl/gost_round.sv
// One Feistel round cell: computes a round on the incoming block and holds the result.
`timescale 1ns / 1ps

module gost_round #(
  parameter int unsigned ROUND_IDX = 0,
  parameter int unsigned SBOX_SET  = gost_pkg::SBOX_SET_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  gost_pkg::cfg_t     cfg,
  input  logic               up_valid,
  output logic               up_stall,
  input  gost_pkg::blk_t     up_blk,
  output logic               dn_valid,
  input  logic               dn_stall,
  output gost_pkg::blk_t     dn_blk
);
  import gost_pkg::*;

  localparam logic LAST_ROUND = (ROUND_IDX == ROUND_COUNT - 1);
  localparam logic SET_SEL    = SBOX_SET[0];

  logic                  valid;
  blk_t                  blk;
  blk_t                  blk_next;
  logic                  load;
  logic [KEY_SEL_W-1:0]  ksel;
  logic [HALF_W-1:0]     sum;
  logic [HALF_W-1:0]     mixed;

  // The cell can take a block when it is empty or its content moves on.
  assign load     = !valid || !dn_stall;
  assign up_stall = !load;

  // Round function: key add, substitution and rotate, then mix with the second half.
  always_comb begin
    ksel  = key_sel(ROUND_W'(ROUND_IDX), cfg.direction);
    sum   = up_blk.first + cfg.key[ksel];
    mixed = round_f(SET_SEL, sum) ^ up_blk.second;
    if (LAST_ROUND) begin
      blk_next.first  = up_blk.first;
      blk_next.second = mixed;
    end else begin
      blk_next.first  = mixed;
      blk_next.second = up_blk.first;
    end
  end

  // Occupancy flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= up_valid;
    end
  end

  // Block halves; held while the next cell stalls.
  always_ff @(posedge clk) begin
    if (load && up_valid) begin
      blk <= blk_next;
    end
  end

  assign dn_valid = valid;
  assign dn_blk   = blk;

endmodule

### rtl/gost_block_cipher_ecb_unit.sv
// Top level of the GOST 28147-89 ECB cipher: config registers and a chain of round cells.
//
//   Channel  Direction  Handshake             Payload
//   in       input      in_valid / in_stall   in_data  (in_first, in_second)
//   out      output     out_valid / out_stall out_data (out_first, out_second)
//   cfg      input      cfg_write             cfg_index, cfg_data
//
// Each block passes through 32 round cells in order. The edge that accepts a
// request loads round cell 0, and the result is shown on out_data from the
// register of round cell 31. A new block can enter every cycle while in_stall is low.
// The cell chain collapses bubbles: a cell loads whenever it is empty or its
// neighbor takes its block, so in_stall rises only when all cells are full and
// out_stall is high. Reset clears the config registers and empties every cell.
`timescale 1ns / 1ps

module gost_block_cipher_ecb_unit #(
  parameter int unsigned SBOX_SET = gost_pkg::SBOX_SET_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [gost_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gost_pkg::CFG_W-1:0]      cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  gost_pkg::in_req_t               in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output gost_pkg::out_req_t              out_data
);
  import gost_pkg::*;

  cfg_t  cfg;
  logic  chain_valid [ROUND_COUNT+1];
  logic  chain_stall [ROUND_COUNT+1];
  blk_t  chain_blk   [ROUND_COUNT+1];

  // Configuration registers.
  gost_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Input side of the chain.
  assign chain_valid[0]     = in_valid;
  assign chain_blk[0].first  = in_data.in_first;
  assign chain_blk[0].second = in_data.in_second;
  assign in_stall            = chain_stall[0];

  // Round cells, one per round.
  for (genvar r = 0; r < ROUND_COUNT; r++) begin : g_round
    gost_round #(
      .ROUND_IDX (r),
      .SBOX_SET  (SBOX_SET)
    ) u_round (
      .clk      (clk),
      .rst      (rst),
      .cfg      (cfg),
      .up_valid (chain_valid[r]),
      .up_stall (chain_stall[r]),
      .up_blk   (chain_blk[r]),
      .dn_valid (chain_valid[r+1]),
      .dn_stall (chain_stall[r+1]),
      .dn_blk   (chain_blk[r+1])
    );
  end

  // Output side: the last cell is the output register.
  assign chain_stall[ROUND_COUNT] = out_stall;
  assign out_valid                = chain_valid[ROUND_COUNT];
  assign out_data.out_first       = chain_blk[ROUND_COUNT].first;
  assign out_data.out_second      = chain_blk[ROUND_COUNT].second;

endmodule

### rtl/gost_chk.sv
// Port-level checker for the GOST ECB cipher unit and its bind statement.
`timescale 1ns / 1ps

module gost_chk (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_stall,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  gost_pkg::out_req_t   out_data
);

  // The chain empties on reset: no result and no back-pressure right after it.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid && !in_stall)
    else $error("chain not empty after reset");

  // Input back-pressure only arises from a stalled, waiting result.
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled result");

  // A stalled result stays and holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  // The chain is empty in the first cycle after reset, so no result can show.
  a_no_early: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !out_valid)
    else $error("result appeared too soon after reset");

endmodule

bind gost_block_cipher_ecb_unit gost_chk u_gost_chk (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
